>>> design/floyd_steinberg_gray_dither_assert.svh
// assertion helpers shared by the dither block
`ifndef FLOYD_STEINBERG_GRAY_DITHER_ASSERT_SVH
`define FLOYD_STEINBERG_GRAY_DITHER_ASSERT_SVH

// same-cycle implication
`define FSGD_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dither assertion failed");

// next-cycle implication
`define FSGD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dither assertion failed");

`endif

>>> design/fsgd_pkg.sv
package fsgd_pkg;

   localparam int MAX_WIDTH_DEFAULT = 1024;
   localparam int PIX_BITS          = 8;
   localparam int FRAME_WIDTH_BITS  = 11;
   localparam int FRAME_HEIGHT_BITS = 16;
   localparam int LEVELS_BITS       = 9;
   localparam int CSR_INDEX_BITS    = 2;
   localparam int CSR_DATA_BITS     = 16;

   localparam logic [FRAME_WIDTH_BITS-1:0]  FRAME_WIDTH_RESET  = 11'd640;
   localparam logic [FRAME_HEIGHT_BITS-1:0] FRAME_HEIGHT_RESET = 16'd480;
   localparam logic [LEVELS_BITS-1:0]       LEVELS_RESET       = 9'd2;
   localparam logic [LEVELS_BITS-1:0]       LEVELS_MIN         = 9'd2;
   localparam logic [LEVELS_BITS-1:0]       LEVELS_MAX         = 9'd256;

   localparam logic [PIX_BITS-1:0] PIX_MAX = 8'd255;

   localparam logic ACTION_PIXEL = 1'b0;
   localparam logic ACTION_FLUSH = 1'b1;

   // diffusion weights
   localparam logic signed [11:0] W_RIGHT      = 12'sd7;
   localparam logic signed [11:0] W_BELOW      = 12'sd5;
   localparam logic signed [11:0] W_BELOW_LEFT = 12'sd3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_LEVELS       = 2'd2
   } fsgd_csr_index_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DECIDE,
      S_QLEVEL,
      S_DIV_LO_INIT,
      S_DIV_LO,
      S_DIV_HI_INIT,
      S_DIV_HI,
      S_QDONE,
      S_RMW_RD,
      S_RMW_WR,
      S_EMIT_CHK,
      S_EMIT_RD,
      S_EMIT_WR,
      S_STORE
   } fsgd_state_type;

   typedef struct packed {
      logic accept;
      logic rd_v;
      logic qlevel;
      logic div_lo_start;
      logic div_hi_start;
      logic div_step;
      logic qdone;
      logic rmw_rd;
      logic rmw_wr;
      logic emit_rd;
      logic emit_wr;
      logic store;
   } fsgd_cmd_type;

   typedef struct packed {
      logic is_flush;
      logic pend_zero;
      logic quant_ok;
      logic div_last;
      logic nb_last;
      logic emit_due;
      logic out_free;
   } fsgd_status_type;

endpackage

>>> design/fsgd_if.sv
interface fsgd_req_if import fsgd_pkg::*;;
   logic                valid;
   logic                ready;
   logic                action;
   logic [PIX_BITS-1:0] pixel_in;
   modport source (output valid, action, pixel_in, input ready);
   modport sink (input valid, action, pixel_in, output ready);
endinterface

interface fsgd_rsp_if import fsgd_pkg::*;;
   logic                valid;
   logic                ready;
   logic [PIX_BITS-1:0] pixel_out;
   logic                frame_end;
   modport source (output valid, pixel_out, frame_end, input ready);
   modport sink (input valid, pixel_out, frame_end, output ready);
endinterface

interface fsgd_csr_if import fsgd_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> design/fsgd_ram.sv
module fsgd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1026
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> design/fsgd_ctrl.sv
module fsgd_ctrl import fsgd_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  fsgd_status_type status,
   output fsgd_cmd_type    cmd
);

   fsgd_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (status.is_flush) begin
               state_in = status.pend_zero ? S_IDLE : S_EMIT_RD;
            end else begin
               state_in = status.quant_ok ? S_QLEVEL : S_EMIT_CHK;
            end
         end
         S_QLEVEL:      state_in = S_DIV_LO_INIT;
         S_DIV_LO_INIT: state_in = S_DIV_LO;
         S_DIV_LO: begin
            if (status.div_last) state_in = S_DIV_HI_INIT;
         end
         S_DIV_HI_INIT: state_in = S_DIV_HI;
         S_DIV_HI: begin
            if (status.div_last) state_in = S_QDONE;
         end
         S_QDONE:  state_in = S_RMW_RD;
         S_RMW_RD: state_in = S_RMW_WR;
         S_RMW_WR: state_in = status.nb_last ? S_EMIT_CHK : S_RMW_RD;
         S_EMIT_CHK: state_in = status.emit_due ? S_EMIT_RD : S_STORE;
         S_EMIT_RD: begin
            if (status.out_free) state_in = S_EMIT_WR;
         end
         S_EMIT_WR: state_in = status.is_flush ? S_IDLE : S_STORE;
         S_STORE:   state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         S_DECIDE:      cmd.rd_v = !status.is_flush && status.quant_ok;
         S_QLEVEL:      cmd.qlevel = 1'b1;
         S_DIV_LO_INIT: cmd.div_lo_start = 1'b1;
         S_DIV_LO:      cmd.div_step = 1'b1;
         S_DIV_HI_INIT: cmd.div_hi_start = 1'b1;
         S_DIV_HI:      cmd.div_step = 1'b1;
         S_QDONE:       cmd.qdone = 1'b1;
         S_RMW_RD:      cmd.rmw_rd = 1'b1;
         S_RMW_WR:      cmd.rmw_wr = 1'b1;
         S_EMIT_RD:     cmd.emit_rd = status.out_free;
         S_EMIT_WR:     cmd.emit_wr = 1'b1;
         S_STORE:       cmd.store = 1'b1;
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

>>> design/fsgd_dp.sv
`include "floyd_steinberg_gray_dither_assert.svh"

module fsgd_dp import fsgd_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  fsgd_cmd_type              cmd,
   output fsgd_status_type           status,
   input  logic                      req_action,
   input  logic [PIX_BITS-1:0]       req_pixel_in,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output logic [PIX_BITS-1:0]       rsp_pixel_out,
   output logic                      rsp_frame_end,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   localparam int DEPTH = MAX_WIDTH + 2;
   localparam int AW    = $clog2(DEPTH);
   localparam int IW    = $clog2(DEPTH + 1);
   localparam int CW    = IW + 1;
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int CLW   = $clog2(MAX_WIDTH);
   localparam int EW    = (WW > FRAME_WIDTH_BITS) ? WW : FRAME_WIDTH_BITS;
   localparam logic [IW:0] DEPTH_S = (IW + 1)'(DEPTH);
   localparam logic [1:0]  NB_LAST = 2'd2;

   // configuration
   logic [FRAME_WIDTH_BITS-1:0]  fw_ff;
   logic [FRAME_HEIGHT_BITS-1:0] fh_ff;
   logic [LEVELS_BITS-1:0]       nc_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff <= FRAME_WIDTH_RESET;
         fh_ff <= FRAME_HEIGHT_RESET;
         nc_ff <= LEVELS_RESET;
      end else if (csr_valid) begin
         case (fsgd_csr_index_type'(csr_index))
            CSR_FRAME_WIDTH:  fw_ff <= csr_data[FRAME_WIDTH_BITS-1:0];
            CSR_FRAME_HEIGHT: fh_ff <= csr_data[FRAME_HEIGHT_BITS-1:0];
            CSR_LEVELS:       nc_ff <= csr_data[LEVELS_BITS-1:0];
            default: ;
         endcase
      end
   end

   // effective sizes
   logic [EW-1:0]                fw_ext;
   logic [WW-1:0]                w_eff;
   logic [FRAME_HEIGHT_BITS-1:0] h_eff;
   logic [LEVELS_BITS-1:0]       n_eff;
   logic [7:0]                   m;

   always_comb begin
      fw_ext = EW'(fw_ff);
      if (fw_ff == '0) begin
         w_eff = WW'(1);
      end else if (fw_ext > EW'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(fw_ext);
      end
      h_eff = (fh_ff == '0) ? FRAME_HEIGHT_BITS'(1) : fh_ff;
      if (nc_ff < LEVELS_MIN) begin
         n_eff = LEVELS_MIN;
      end else if (nc_ff > LEVELS_MAX) begin
         n_eff = LEVELS_MAX;
      end else begin
         n_eff = nc_ff;
      end
      m = 8'(n_eff - 9'd1);
   end

   // window bookkeeping
   logic [IW-1:0]                pending_ff;
   logic [AW-1:0]                head_ff;
   logic [FRAME_HEIGHT_BITS-1:0] row_ff;
   logic [CLW-1:0]               col_ff;
   logic                         action_ff;
   logic [PIX_BITS-1:0]          incoming_ff;
   logic                         k_ff;

   logic [CW-1:0]                pend_c, w_c;
   logic [WW-1:0]                col_p1;
   logic [FRAME_HEIGHT_BITS:0]   row_p1;
   logic                         col_wrap, row_wrap;
   logic [CLW-1:0]               adv_col, qc;
   logic [FRAME_HEIGHT_BITS-1:0] adv_row, qr;
   logic                         k_is1, quant_range, interior;
   logic                         pend_full, store_ok;

   always_comb begin
      pend_c   = CW'(pending_ff);
      w_c      = CW'(w_eff);
      col_p1   = WW'(col_ff) + WW'(1);
      row_p1   = (FRAME_HEIGHT_BITS + 1)'(row_ff) + 1'b1;
      col_wrap = col_p1 >= w_eff;
      row_wrap = row_p1 >= (FRAME_HEIGHT_BITS + 1)'(h_eff);
      adv_col  = col_wrap ? '0 : CLW'(col_p1);
      if (col_wrap) begin
         adv_row = row_wrap ? '0 : row_p1[FRAME_HEIGHT_BITS-1:0];
      end else begin
         adv_row = row_ff;
      end
      k_is1       = pend_c == w_c + CW'(2);
      quant_range = (pend_c == w_c + CW'(1)) || k_is1;
      qr          = k_is1 ? adv_row : row_ff;
      qc          = k_is1 ? adv_col : col_ff;
      interior    = (qr != '0)
                 && ((FRAME_HEIGHT_BITS + 1)'(qr) + 2'd2
                     <= (FRAME_HEIGHT_BITS + 1)'(h_eff))
                 && (qc != '0)
                 && ((WW + 1)'(qc) + 2'd2 <= (WW + 1)'(w_eff));
      pend_full   = (IW + 1)'(pending_ff) >= DEPTH_S;
      store_ok    = cmd.store && !pend_full;
   end

   function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                          input logic [IW-1:0] idx);
      logic [IW:0] sum;
      sum = (IW + 1)'(head) + (IW + 1)'(idx);
      if (sum >= DEPTH_S) sum = sum - DEPTH_S;
      return AW'(sum);
   endfunction

   function automatic logic signed [8:0] div16(input logic signed [11:0] x);
      logic signed [11:0] t;
      t = (x < 0) ? x + 12'sd15 : x;
      return 9'(t >>> 4);
   endfunction

   function automatic logic [PIX_BITS-1:0] clamp_add(input logic [PIX_BITS-1:0] p,
                                                    input logic signed [8:0] t);
      logic signed [9:0] s;
      s = $signed({2'b00, p}) + 10'(t);
      if (s < 0) return '0;
      if (s > 10'sd255) return PIX_MAX;
      return s[PIX_BITS-1:0];
   endfunction

   // level search
   logic [PIX_BITS-1:0] v_ff, kl_ff, lo_ff;
   logic [15:0]         prod_ff;
   logic [7:0]          rem_ff, sh_ff, quo_ff;
   logic [2:0]          dcnt_ff;
   logic [16:0]         d255_t;
   logic [PIX_BITS-1:0] kl_c;
   logic [8:0]          step_t;
   logic                step_ge;
   logic [15:0]         num_lo, num_hi;

   always_comb begin
      // divide by 255 through a shifted add, exact over 16 bits
      d255_t  = 17'(prod_ff) + 17'd1;
      kl_c    = 8'((d255_t + (d255_t >> 8)) >> 8);
      num_lo  = {kl_c, 8'd0} - 16'(kl_c);
      num_hi  = {kl_ff + 8'd1, 8'd0} - 16'(kl_ff + 8'd1);
      step_t  = {rem_ff, sh_ff[7]};
      step_ge = step_t >= {1'b0, m};
   end

   // neighbour walk
   logic [1:0]    nb_ff;
   logic [IW-1:0] nb_idx;

   logic [PIX_BITS-1:0] nv_c;
   logic signed [8:0]   e_c, e_ff, dlo, dhi, t_sel;
   logic signed [11:0]  e_ext;

   always_comb begin
      dlo = $signed({1'b0, v_ff}) - $signed({1'b0, lo_ff});
      dhi = $signed({1'b0, quo_ff}) - $signed({1'b0, v_ff});
      if (v_ff == PIX_MAX) begin
         nv_c = PIX_MAX;
      end else if (v_ff == '0) begin
         nv_c = '0;
      end else begin
         nv_c = (dlo <= dhi) ? lo_ff : quo_ff;
      end
      e_c   = $signed({1'b0, v_ff}) - $signed({1'b0, nv_c});
      e_ext = 12'(e_ff);
      case (nb_ff)
         2'd0:    t_sel = div16(e_ext * W_RIGHT);
         2'd1:    t_sel = div16(e_ext * W_BELOW);
         default: t_sel = div16(e_ext * W_BELOW_LEFT);
      endcase
   end

   always_comb begin
      case (nb_ff)
         2'd0:    nb_idx = IW'(k_ff) + IW'(1);
         2'd1:    nb_idx = IW'(k_ff) + IW'(w_eff);
         default: nb_idx = IW'(k_ff) + IW'(w_eff) - IW'(1);
      endcase
   end

   // window memory
   logic                ram_we, ram_re;
   logic [AW-1:0]       ram_waddr, ram_raddr;
   logic [PIX_BITS-1:0] ram_wdata, ram_rdata;

   always_comb begin
      ram_re    = cmd.rd_v || cmd.rmw_rd || cmd.emit_rd;
      ram_raddr = head_ff;
      if (cmd.rd_v) ram_raddr = phys(head_ff, IW'(k_is1));
      else if (cmd.rmw_rd) ram_raddr = phys(head_ff, nb_idx);
      ram_we    = 1'b0;
      ram_waddr = phys(head_ff, pending_ff);
      ram_wdata = incoming_ff;
      if (cmd.qdone) begin
         ram_we    = 1'b1;
         ram_waddr = phys(head_ff, IW'(k_ff));
         ram_wdata = nv_c;
      end else if (cmd.rmw_wr) begin
         ram_we    = 1'b1;
         ram_waddr = phys(head_ff, nb_idx);
         ram_wdata = clamp_add(ram_rdata, t_sel);
      end else if (cmd.store) begin
         ram_we = store_ok;
      end
   end

   fsgd_ram #(
      .WIDTH (PIX_BITS),
      .DEPTH (DEPTH)
   ) u_window (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // result word
   logic                rsp_valid_ff;
   logic [PIX_BITS-1:0] rsp_pixel_ff;
   logic                rsp_frame_end_ff;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_out = rsp_pixel_ff;
   assign rsp_frame_end = rsp_frame_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= '0;
         head_ff      <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         nb_ff        <= '0;
         dcnt_ff      <= '0;
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         if (cmd.accept) begin
            action_ff   <= req_action;
            incoming_ff <= req_pixel_in;
         end
         if (cmd.rd_v) k_ff <= k_is1;
         if (cmd.qlevel) begin
            v_ff    <= ram_rdata;
            prod_ff <= 16'(ram_rdata) * 16'(m);
         end
         if (cmd.div_lo_start || cmd.div_hi_start) begin
            rem_ff  <= cmd.div_lo_start ? num_lo[15:8] : num_hi[15:8];
            sh_ff   <= cmd.div_lo_start ? num_lo[7:0] : num_hi[7:0];
            quo_ff  <= '0;
            dcnt_ff <= '0;
         end
         if (cmd.div_lo_start) kl_ff <= kl_c;
         if (cmd.div_hi_start) lo_ff <= quo_ff;
         if (cmd.div_step) begin
            rem_ff  <= step_ge ? 8'(step_t - {1'b0, m}) : step_t[7:0];
            sh_ff   <= {sh_ff[6:0], 1'b0};
            quo_ff  <= {quo_ff[6:0], step_ge};
            dcnt_ff <= dcnt_ff + 3'd1;
         end
         if (cmd.qdone) begin
            e_ff        <= e_c;
            nb_ff       <= '0;
            incoming_ff <= clamp_add(incoming_ff, div16(12'(e_c)));
         end
         if (cmd.rmw_wr) nb_ff <= nb_ff + 2'd1;
         if (cmd.emit_wr) begin
            rsp_valid_ff     <= 1'b1;
            rsp_pixel_ff     <= ram_rdata;
            rsp_frame_end_ff <= col_wrap && row_wrap;
            head_ff          <= ((AW + 1)'(head_ff) + 1'b1 == (AW + 1)'(DEPTH))
                                ? '0 : head_ff + AW'(1);
            pending_ff       <= pending_ff - IW'(1);
            row_ff           <= adv_row;
            col_ff           <= adv_col;
         end
         if (store_ok) pending_ff <= pending_ff + IW'(1);
      end
   end

   always_comb begin
      status.is_flush  = action_ff == ACTION_FLUSH;
      status.pend_zero = pending_ff == '0;
      status.quant_ok  = quant_range && interior;
      status.div_last  = dcnt_ff == 3'd7;
      status.nb_last   = nb_ff == NB_LAST;
      status.emit_due  = pend_c >= w_c + CW'(2);
      status.out_free  = !rsp_valid_ff || rsp_ready;
   end

   // the result slot is free whenever a new word is loaded
   `FSGD_ASSERT_IMPL(a_load_free, clock, reset, cmd.emit_wr, !rsp_valid_ff)
   // the pending count never passes the window depth
   `FSGD_ASSERT_IMPL(a_pend_bound, clock, reset, 1'b1, (IW + 1)'(pending_ff) <= DEPTH_S)
   // a store into a window with room grows the count by one
   `FSGD_ASSERT_NEXT(a_store_grow, clock, reset, store_ok, pending_ff == $past(pending_ff) + IW'(1))

endmodule

>>> design/floyd_steinberg_gray_dither.sv
// Floyd-Steinberg gray dither: takes gray pixels in raster order and returns
// each one frame_width+2 words later, dithered toward a palette of evenly
// spaced levels whose count is a configuration register (border rows and
// columns pass through but still pick up diffused error); flush words drain
// pending pixels one per word. One word is handled at a time, from its
// accept to the next possible accept: a flush ends at once when nothing is
// pending, or after it drains a pixel; a pixel that needs no quantization is
// stored, after it pushes out a result when one is due; an interior pixel
// first runs the level search and the neighbour updates. The time per word is
// set by the two 8-step restoring divisions of the level search and by the
// window memory, which takes the quantized value and the three neighbour
// read-modify-writes one access at a time. While the result word waits for
// the receiver the block holds off its input. No clearing pass after reset.
module floyd_steinberg_gray_dither import fsgd_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
   input logic         clock,
   input logic         reset,
   fsgd_req_if.sink    req_ch,
   fsgd_rsp_if.source  rsp_ch,
   fsgd_csr_if.sink    csr_ch
);

   fsgd_cmd_type    cmd;
   fsgd_status_type status;

   fsgd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   fsgd_dp #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_action    (req_ch.action),
      .req_pixel_in  (req_ch.pixel_in),
      .rsp_ready     (rsp_ch.ready),
      .rsp_valid     (rsp_ch.valid),
      .rsp_pixel_out (rsp_ch.pixel_out),
      .rsp_frame_end (rsp_ch.frame_end),
      .csr_valid     (csr_ch.valid),
      .csr_ready     (csr_ch.ready),
      .csr_index     (csr_ch.index),
      .csr_data      (csr_ch.data)
   );

endmodule
